// ===== src/odtg_pkg.sv =====
// ----------------------------------------------------------------------------
// odtg_pkg
// Shared types, codes and constant wave tables of the decaying tone generator.
// ----------------------------------------------------------------------------
`default_nettype none

package odtg_pkg;

  localparam int ROM_BITS = 10;
  localparam int ROM_SIZE = 1 << ROM_BITS;
  localparam int QUARTER  = ROM_SIZE / 4;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_WAVEFORM   = 2'd0;
  localparam cfg_idx_t CFG_CLICK_LEN  = 2'd1;
  localparam cfg_idx_t CFG_PHASE_STEP = 2'd2;
  localparam cfg_idx_t CFG_NOISE_SEED = 2'd3;

  typedef logic [2:0] wave_code_t;
  localparam wave_code_t WAVE_CLICK = 3'd0;
  localparam wave_code_t WAVE_SINE  = 3'd1;
  localparam wave_code_t WAVE_RECT  = 3'd2;
  localparam wave_code_t WAVE_TRI   = 3'd3;
  localparam wave_code_t WAVE_NOISE = 3'd4;

  localparam logic [10:0] CLICK_LEN_RESET = 11'd88;
  localparam logic [31:0] STEP_RESET      = 32'd42852282;
  localparam logic [31:0] SEED_RESET      = 32'd1;
  localparam logic [31:0] LFSR_TAPS       = 32'h80200003;
  localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_IDX,
    S_WAVE,
    S_MUL,
    S_DIVGO,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic div_idx;
    logic div_amp;
    logic wave;
    logic mul;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic active;
    logic tone;
    logic div_done;
    logic out_free;
  } dp_status_t;

  typedef logic signed [17:0] rom_word_t;
  typedef rom_word_t rom_t [ROM_SIZE];

  // shift-and-subtract quotient for the table build
  function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
    longint unsigned qv;
    longint unsigned rv;
    qv = '0;
    rv = '0;
    for (int i = 63; i >= 0; i--) begin
      rv = {rv[62:0], a[i]};
      if (rv >= b) begin
        rv    = rv - b;
        qv[i] = 1'b1;
      end
    end
    return qv;
  endfunction

  function automatic rom_t exp_table();
    rom_t            tbl;
    longint unsigned x;
    longint unsigned term;
    longint unsigned e;
    longint          sum;
    for (int k = 0; k < ROM_SIZE; k++) begin
      x    = longint'(k) << (30 - ROM_BITS);
      term = 64'd1 << 30;
      sum  = longint'(term);
      for (int n = 1; n <= 14; n++) begin
        term = udiv64((term * x) >> 30, longint'(n));
        if ((n & 1) != 0) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      e = (sum < 0) ? 64'd0 : longint'(sum);
      for (int s = 0; s < 3; s++) begin
        e = (e * e + (64'd1 << 29)) >> 30;
      end
      tbl[k] = 18'((e + 64'd16384) >> 15);
    end
    return tbl;
  endfunction

  function automatic rom_t sin_table();
    rom_t            tbl;
    longint unsigned y;
    longint unsigned t;
    longint          s2;
    longint unsigned v;
    int              q;
    int              r;
    int              ang;
    for (int k = 0; k < ROM_SIZE; k++) begin
      q   = k >> (ROM_BITS - 2);
      r   = k & (QUARTER - 1);
      ang = ((q & 1) != 0) ? QUARTER - r : r;
      y   = (longint'(ang) * TWO_PI_Q30) >> ROM_BITS;
      t   = y;
      s2  = longint'(y);
      for (int n = 3; n <= 17; n += 2) begin
        t = (t * y) >> 30;
        t = (t * y) >> 30;
        t = udiv64(t, longint'((n - 1) * n));
        if (((n >> 1) & 1) != 0) begin
          s2 = s2 - longint'(t);
        end else begin
          s2 = s2 + longint'(t);
        end
      end
      v = (s2 < 0) ? 64'd0 : ((longint'(s2) + 64'd16384) >> 15);
      tbl[k] = (q >= 2) ? -rom_word_t'(18'(v)) : rom_word_t'(18'(v));
    end
    return tbl;
  endfunction

  localparam rom_t EXP_ROM = exp_table();
  localparam rom_t SIN_ROM = sin_table();

endpackage

`default_nettype wire

// ===== src/odtg_if.sv =====
// ----------------------------------------------------------------------------
// odtg channel interfaces
// Valid/ready channels for trigger ticks and generated samples.
// ----------------------------------------------------------------------------
`default_nettype none

interface odtg_in_if;
  logic valid;
  logic ready;
  logic trigger;
  modport source (output valid, output trigger, input ready);
  modport sink (input valid, input trigger, output ready);
endinterface

interface odtg_out_if #(parameter int SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           active;
  modport source (output valid, output sample, output active, input ready);
  modport sink (input valid, input sample, input active, output ready);
endinterface

`default_nettype wire

// ===== src/odtg_div.sv =====
// ----------------------------------------------------------------------------
// odtg_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module odtg_div #(
  parameter int NW = 43,
  parameter int DW = 26,
  parameter int QW = 17
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic      [QW-1:0] quo,
  output logic               done
);

  localparam int CNT_W = $clog2(QW + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [QW-1:0]    low_r, low_nxt;
  logic [QW-1:0]    q_r, q_nxt;
  logic [DW-1:0]    den_r, den_nxt;
  logic [DW:0]      trial;
  logic             fits;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    trial    = {rem_r, low_r[QW-1]};
    fits     = trial >= {1'b0, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(QW);
      rem_nxt  = num[NW-1:QW];
      low_nxt  = num[QW-1:0];
      q_nxt    = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt  = fits ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      low_nxt  = {low_r[QW-2:0], 1'b0};
      q_nxt    = {q_r[QW-2:0], fits};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != CNT_W'(1));
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign quo  = q_r;
  assign done = done_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");

endmodule

`default_nettype wire

// ===== src/odtg_dp.sv =====
// ----------------------------------------------------------------------------
// odtg_dp
// Datapath: registers, burst state, wave select, envelope scaling, output.
// ----------------------------------------------------------------------------
`default_nettype none

module odtg_dp import odtg_pkg::*; #(
  parameter int TABLE_LENGTH = 1024,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire cfg_idx_t                       cfg_index,
  input  wire logic [31:0]                    cfg_data,
  input  wire logic                           in_trigger,
  input  wire dp_cmd_t                        cmd,
  output dp_status_t                          status,
  input  wire logic                           out_ready,
  output logic                                out_valid,
  output logic signed [SAMPLE_WIDTH-1:0]      out_sample,
  output logic                                out_active
);

  localparam int LEN_W = $clog2(TABLE_LENGTH + 1);
  localparam int DW    = LEN_W + 15;
  localparam int QW    = (SAMPLE_WIDTH + 1 > 11) ? SAMPLE_WIDTH + 1 : 11;
  localparam int NW    = DW + QW;
  localparam int PW    = 16 + LEN_W;
  localparam int CW    = (LEN_W > 11) ? LEN_W : 11;
  localparam logic [QW-1:0] FS    = QW'(1) << (SAMPLE_WIDTH - 1);
  localparam logic [QW-1:0] FS_M1 = FS - QW'(1);

  wave_code_t                     waveform_r;
  logic [10:0]                    click_len_r;
  logic [31:0]                    step_r;
  logic [31:0]                    seed_r;
  logic [LEN_W-1:0]               pos_r;
  logic [LEN_W-1:0]               remain_r;
  logic [LEN_W-1:0]               blen_r;
  logic [31:0]                    phase_r;
  logic [31:0]                    lfsr_r;
  rom_word_t                      w_r;
  logic                           neg_r;
  logic [PW-1:0]                  prod_r;
  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r;
  logic                           out_active_r;

  logic                           tone;
  logic                           active;
  logic [CW-1:0]                  click_ext;
  logic [LEN_W-1:0]               trig_len;
  logic [QW-1:0]                  div_q;
  logic                           div_done;
  logic [NW-1:0]                  div_num;
  logic [DW-1:0]                  div_den;
  logic [ROM_BITS-1:0]            exp_idx;
  logic [31:0]                    tri_u;
  rom_word_t                      exp_w;
  rom_word_t                      wave;
  rom_word_t                      w_abs;
  logic [QW-1:0]                  q_sat;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic [31:0]                    lfsr_step;

  assign tone   = (waveform_r >= WAVE_SINE) && (waveform_r <= WAVE_NOISE);
  assign active = (remain_r != '0);

  always_comb begin
    click_ext = CW'(click_len_r);
    if (tone) begin
      trig_len = LEN_W'(TABLE_LENGTH);
    end else if (click_ext == '0) begin
      trig_len = LEN_W'(1);
    end else if (click_ext > CW'(TABLE_LENGTH)) begin
      trig_len = LEN_W'(TABLE_LENGTH);
    end else begin
      trig_len = LEN_W'(click_ext);
    end
  end

  always_comb begin
    if (cmd.div_amp) begin
      div_num = NW'({prod_r, {(SAMPLE_WIDTH - 1){1'b0}}}) + (NW'(blen_r) << 14);
      div_den = {blen_r, 15'd0};
    end else begin
      div_num = NW'({pos_r, {ROM_BITS{1'b0}}});
      div_den = DW'(blen_r);
    end
  end

  odtg_div #(
    .NW (NW),
    .DW (DW),
    .QW (QW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_idx | cmd.div_amp),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_q),
    .done  (div_done)
  );

  always_comb begin
    exp_idx = (div_q > QW'(ROM_SIZE - 1)) ? ROM_BITS'(ROM_SIZE - 1) : div_q[ROM_BITS-1:0];
    exp_w   = EXP_ROM[exp_idx];
    tri_u   = phase_r[31] ? {1'b0, phase_r[30:0]} : 32'h8000_0000 - phase_r;
    case (waveform_r)
      WAVE_SINE:  wave = SIN_ROM[phase_r[31 -: ROM_BITS]];
      WAVE_RECT:  wave = phase_r[31] ? -18'sd32768 : 18'sd32768;
      WAVE_TRI:   wave = $signed({1'b0, tri_u[31:15]}) - 18'sd32768;
      WAVE_NOISE: wave = $signed({2'b00, lfsr_r[31:16]}) - 18'sd32768;
      default:    wave = pos_r[0] ? -exp_w : exp_w;
    endcase
  end

  assign w_abs = w_r[17] ? -w_r : w_r;

  always_comb begin
    if (neg_r) begin
      q_sat  = (div_q > FS) ? FS : div_q;
      sample = -SAMPLE_WIDTH'(q_sat);
    end else begin
      q_sat  = (div_q > FS_M1) ? FS_M1 : div_q;
      sample = SAMPLE_WIDTH'(q_sat);
    end
  end

  assign lfsr_step = lfsr_r[0] ? ((lfsr_r >> 1) ^ LFSR_TAPS) : (lfsr_r >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waveform_r  <= WAVE_CLICK;
      click_len_r <= CLICK_LEN_RESET;
      step_r      <= STEP_RESET;
      seed_r      <= SEED_RESET;
      pos_r       <= '0;
      remain_r    <= '0;
      blen_r      <= '0;
      phase_r     <= '0;
      lfsr_r      <= 32'd1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WAVEFORM: begin
            waveform_r <= cfg_data[2:0];
            remain_r   <= '0;
            pos_r      <= '0;
          end
          CFG_CLICK_LEN:  click_len_r <= cfg_data[10:0];
          CFG_PHASE_STEP: step_r      <= cfg_data;
          CFG_NOISE_SEED: seed_r      <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load && in_trigger) begin
        blen_r   <= trig_len;
        remain_r <= trig_len;
        pos_r    <= '0;
        phase_r  <= '0;
        lfsr_r   <= (seed_r == '0) ? 32'd1 : seed_r;
      end
      if (cmd.emit && active) begin
        pos_r    <= pos_r + 1'b1;
        remain_r <= remain_r - 1'b1;
        phase_r  <= phase_r + step_r;
        lfsr_r   <= lfsr_step;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wave) begin
      w_r <= wave;
    end
    if (cmd.mul) begin
      prod_r <= PW'(w_abs[15:0]) * PW'(remain_r);
      neg_r  <= w_r[17];
    end
    if (cmd.emit) begin
      out_sample_r <= active ? sample : '0;
      out_active_r <= active;
    end
  end

  assign status.active   = active;
  assign status.tone     = tone;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_active = out_active_r;

  a_burst_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (remain_r != '0) |-> ((LEN_W + 1)'(pos_r) + (LEN_W + 1)'(remain_r)
                          == (LEN_W + 1)'(blen_r)))
    else $error("burst position and remaining count disagree");

  a_lfsr_live: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_r != '0) else $error("noise register locked at zero");

endmodule

`default_nettype wire

// ===== src/odtg_ctrl.sv =====
// ----------------------------------------------------------------------------
// odtg_ctrl
// Sequencer: accept a tick, run index and envelope divisions, emit a sample.
// ----------------------------------------------------------------------------
`default_nettype none

module odtg_ctrl import odtg_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output dp_cmd_t         cmd,
  input  wire dp_status_t status
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (!status.active) begin
          state_nxt = S_EMIT;
        end else if (status.tone) begin
          state_nxt = S_WAVE;
        end else begin
          cmd.div_idx = 1'b1;
          state_nxt   = S_IDX;
        end
      end
      S_IDX: begin
        if (status.div_done) begin
          state_nxt = S_WAVE;
        end
      end
      S_WAVE: begin
        cmd.wave  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIVGO;
      end
      S_DIVGO: begin
        cmd.div_amp = 1'b1;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    status.div_done |-> (state_r == S_IDX || state_r == S_DIV))
    else $error("division finished outside a wait state");

endmodule

`default_nettype wire

// ===== src/one_shot_decaying_tone_generator.sv =====
// ----------------------------------------------------------------------------
// one_shot_decaying_tone_generator
// Triggered burst of click, sine, rectangle, triangle or noise under a linear
// decay envelope, one sample per input tick.
//
//   channel | dir | payload          | handshake
//   in_ch   | in  | trigger          | valid/ready
//   out_ch  | out | sample, active   | valid/ready
//   cfg_*   | in  | index, data      | write enable only
//
// A tone tick runs one envelope division and a click tick an index division
// as well, on the shared serial divider with QW = max(SAMPLE_WIDTH+1, 11)
// quotient bits; an idle tick skips the divider and goes straight to emit.
// Reset is synchronous; the wave tables are constants and need no fill.
// One output register holds a finished transaction; a new tick is taken
// while it waits, and the next one stalls at emit until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module one_shot_decaying_tone_generator import odtg_pkg::*; #(
  parameter int TABLE_LENGTH = 1024,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire cfg_idx_t    cfg_index,
  input  wire logic [31:0] cfg_data,
  odtg_in_if.sink          in_ch,
  odtg_out_if.source       out_ch
);

  dp_cmd_t    cmd;
  dp_status_t status;

  odtg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .status   (status)
  );

  odtg_dp #(
    .TABLE_LENGTH (TABLE_LENGTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_trigger (in_ch.trigger),
    .cmd        (cmd),
    .status     (status),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_sample (out_ch.sample),
    .out_active (out_ch.active)
  );

endmodule

`default_nettype wire

// ===== verif/tb_one_shot_decaying_tone_generator.sv =====
// ----------------------------------------------------------------------------
// tb_one_shot_decaying_tone_generator
// Drives trigger ticks in random bursts against a stalling sample sink and
// checks every generated sample against a cycle-free model of the generator,
// over all waveforms and random click lengths, phase steps and noise seeds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_one_shot_decaying_tone_generator;
  import odtg_pkg::*;

  localparam int TABLE_LENGTH = 1024;
  localparam int SAMPLE_WIDTH = 16;
  localparam int IDLE_LIMIT   = 20000;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           active;
  } tick_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  cfg_idx_t    cfg_index = CFG_WAVEFORM;
  logic [31:0] cfg_data = '0;

  odtg_in_if                               in_ch();
  odtg_out_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) out_ch();

  one_shot_decaying_tone_generator #(
    .TABLE_LENGTH(TABLE_LENGTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // model state
  logic [2:0]    gen_wave;
  logic [10:0]   gen_click_len;
  logic [31:0]   gen_step;
  logic [31:0]   gen_seed;
  int unsigned   gen_pos;
  int unsigned   gen_remaining;
  int unsigned   gen_len;
  logic [31:0]   gen_phase;
  logic [31:0]   gen_lfsr;
  rom_word_t     exp_tab [ROM_SIZE];
  rom_word_t     sin_tab [ROM_SIZE];

  tick_result_t  pending_samples [$];
  int            error_count = 0;
  int            sample_count = 0;
  int            trigger_count = 0;
  int            idle_cycles = 0;
  int            stall_mode = 0;
  logic          burst_mode = 1'b0;

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.trigger = 1'b0;
    out_ch.ready  = 1'b0;
  end

  // independent table build, same integer series as the package functions
  function automatic void build_tables();
    longint unsigned x, term, e, y, t, v;
    longint          sum, s2;
    int              q, r, ang;
    for (int k = 0; k < ROM_SIZE; k++) begin
      x = longint'(k) << (30 - ROM_BITS);
      term = 64'd1 << 30;
      sum = longint'(term);
      for (int n = 1; n <= 14; n++) begin
        term = ((term * x) >> 30) / n;
        sum = (n % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
      end
      e = (sum < 0) ? 0 : sum;
      for (int s = 0; s < 3; s++) e = (e * e + (64'd1 << 29)) >> 30;
      exp_tab[k] = 18'((e + 64'd16384) >> 15);
      q = k / (ROM_SIZE / 4);
      r = k % (ROM_SIZE / 4);
      ang = (q % 2 == 1) ? ROM_SIZE / 4 - r : r;
      y = (longint'(ang) * 64'd6746518852) >> ROM_BITS;
      t = y;
      s2 = longint'(y);
      for (int n = 3; n <= 17; n += 2) begin
        t = (t * y) >> 30;
        t = (t * y) >> 30;
        t = t / ((n - 1) * n);
        s2 = ((n / 2) % 2 == 1) ? s2 - longint'(t) : s2 + longint'(t);
      end
      v = (s2 < 0) ? 0 : ((s2 + 64'd16384) >> 15);
      sin_tab[k] = (q >= 2) ? -rom_word_t'(v) : rom_word_t'(v);
    end
  endfunction

  function automatic void model_reset();
    gen_wave = WAVE_CLICK;
    gen_click_len = 11'd88;
    gen_step = 32'd42852282;
    gen_seed = 32'd1;
    gen_pos = 0;
    gen_remaining = 0;
    gen_len = 0;
    gen_phase = '0;
    gen_lfsr = 32'd1;
  endfunction

  function automatic tick_result_t predict_tick(logic trig);
    tick_result_t    res;
    longint          w;
    longint unsigned mag, num, den, qt, fs, idx;
    logic [31:0]     u;
    int unsigned     len;
    fs = 64'd1 << (SAMPLE_WIDTH - 1);
    if (trig) begin
      len = TABLE_LENGTH;
      if (!(gen_wave >= WAVE_SINE && gen_wave <= WAVE_NOISE)) begin
        len = gen_click_len;
        if (len < 1) len = 1;
        if (len > TABLE_LENGTH) len = TABLE_LENGTH;
      end
      gen_len = len;
      gen_remaining = len;
      gen_pos = 0;
      gen_phase = '0;
      gen_lfsr = (gen_seed != 0) ? gen_seed : 32'd1;
    end
    if (gen_remaining == 0) begin
      res.sample = '0;
      res.active = 1'b0;
      return res;
    end
    len = (gen_len != 0) ? gen_len : 1;
    case (gen_wave)
      WAVE_SINE: w = sin_tab[gen_phase[31:32-ROM_BITS]];
      WAVE_RECT: w = gen_phase[31] ? -32768 : 32768;
      WAVE_TRI: begin
        u = gen_phase[31] ? gen_phase - 32'h80000000 : 32'h80000000 - gen_phase;
        w = longint'(u >> 15) - 32768;
      end
      WAVE_NOISE: w = longint'(gen_lfsr >> 16) - 32768;
      default: begin
        idx = (longint'(gen_pos) * ROM_SIZE) / len;
        if (idx > ROM_SIZE - 1) idx = ROM_SIZE - 1;
        w = exp_tab[idx];
        if (gen_pos % 2 == 1) w = -w;
      end
    endcase
    mag = (w < 0) ? -w : w;
    num = mag * gen_remaining * fs;
    den = longint'(len) << 15;
    qt = (num + den / 2) / den;
    if (w < 0) begin
      if (qt > fs) qt = fs;
      res.sample = SAMPLE_WIDTH'(-longint'(qt));
    end else begin
      if (qt > fs - 1) qt = fs - 1;
      res.sample = SAMPLE_WIDTH'(qt);
    end
    res.active = 1'b1;
    gen_pos++;
    gen_remaining--;
    gen_phase = gen_phase + gen_step;
    gen_lfsr = gen_lfsr[0] ? ((gen_lfsr >> 1) ^ LFSR_TAPS) : (gen_lfsr >> 1);
    return res;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WAVEFORM: begin
        gen_wave = value[2:0];
        gen_remaining = 0;
        gen_pos = 0;
      end
      CFG_CLICK_LEN:  gen_click_len = value[10:0];
      CFG_PHASE_STEP: gen_step = value;
      default:        gen_seed = value;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // sender: random bursts and gaps
  task automatic send_tick(logic trig);
    if (!burst_mode) begin
      @(negedge clk);
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_mode = 1'b1;
    end else begin
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.trigger <= trig;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_samples.push_back(predict_tick(trig));
    if (trig) trigger_count++;
    if ($urandom_range(0, 9) == 0) burst_mode = 1'b0;
    @(negedge clk);
    if (!burst_mode) in_ch.valid <= 1'b0;
  endtask

  task automatic finish_sends();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_mode = 1'b0;
  endtask

  // run a burst: trigger then idle ticks, with occasional retriggers
  task automatic play_burst(int ticks, int retrig_pct);
    send_tick(1'b1);
    for (int i = 1; i < ticks; i++)
      send_tick($urandom_range(0, 99) < retrig_pct);
    finish_sends();
  endtask

  task automatic test_directed();
    write_reg(CFG_CLICK_LEN, 32'd4);
    play_burst(6, 0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    finish_sends();
    wait_drained();
    write_reg(CFG_CLICK_LEN, 32'd0);
    play_burst(2, 0);
    wait_drained();
    write_reg(CFG_CLICK_LEN, 32'd1);
    play_burst(2, 0);
    wait_drained();
    write_reg(CFG_CLICK_LEN, 32'h7FF);
    write_reg(CFG_WAVEFORM, 32'd7);
    play_burst(3, 0);
    wait_drained();
    write_reg(CFG_PHASE_STEP, 32'hFFFFFFFF);
    write_reg(CFG_NOISE_SEED, 32'd0);
    for (int wv = WAVE_SINE; wv <= WAVE_NOISE; wv++) begin
      write_reg(CFG_WAVEFORM, 32'(wv));
      play_burst(2, 0);
      wait_drained();
    end
    write_reg(CFG_PHASE_STEP, 32'h40000000);
    write_reg(CFG_NOISE_SEED, 32'hFFFFFFFF);
    write_reg(CFG_WAVEFORM, 32'(WAVE_TRI));
    play_burst(3, 0);
    wait_drained();
  endtask

  task automatic test_random(int total);
    int sent;
    int n;
    sent = 0;
    while (sent < total) begin
      write_reg(CFG_WAVEFORM, 32'($urandom_range(0, 7)));
      case ($urandom_range(0, 3))
        0: write_reg(CFG_CLICK_LEN, 32'($urandom_range(0, 2047)));
        1: write_reg(CFG_CLICK_LEN, 32'($urandom_range(1, 16)));
        default: write_reg(CFG_CLICK_LEN, 32'($urandom_range(1, 120)));
      endcase
      write_reg(CFG_PHASE_STEP, $urandom());
      write_reg(CFG_NOISE_SEED, ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom());
      stall_mode = $urandom_range(0, 3);
      n = $urandom_range(20, 140);
      play_burst(n, $urandom_range(0, 4));
      sent += n;
      wait_drained();
    end
  endtask

  // sink: stall pattern of its own
  always @(negedge clk) begin
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: out_ch.ready <= ~out_ch.ready;
    endcase
  end

  always @(posedge clk) begin
    tick_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sample_count++;
      if (pending_samples.size() == 0) begin
        $error("unexpected sample transaction %0d", out_ch.sample);
        error_count++;
      end else begin
        want = pending_samples.pop_front();
        if (out_ch.sample !== want.sample) begin
          $error("sample: expected %0d, got %0d", want.sample, out_ch.sample);
          error_count++;
        end
        if (out_ch.active !== want.active) begin
          $error("active: expected %0b, got %0b", want.active, out_ch.active);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we ||
        (pending_samples.size() == 0 && !in_ch.valid))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_one_shot_decaying_tone_generator: errors");
      $finish;
    end
  end

  initial begin
    build_tables();
    model_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(1950);
    wait_drained();
    if (pending_samples.size() != 0) error_count++;
    $display("Covered %0d samples from %0d triggers over all waveforms and settings.",
             sample_count, trigger_count);
    if (error_count == 0) begin
      $display("tb_one_shot_decaying_tone_generator: clean");
    end else begin
      $display("tb_one_shot_decaying_tone_generator: errors");
    end
    $finish;
  end

endmodule
